### rtl/css_pkg.sv
// Shared types, constants and helpers for the caseless substring search block.
// No dependencies; every other file of the block but css_cell uses this package.
package css_pkg;

  // window and offset sizing
  localparam int NEEDLE_MAX   = 32;
  localparam int OFFSET_WIDTH = 16;

  // needle storage: four 64-bit chunks of eight bytes each
  localparam int CHUNK_COUNT     = 4;
  localparam int BYTES_PER_CHUNK = 8;
  localparam int CHUNK_W         = 64;
  localparam int REG_BYTES       = CHUNK_COUNT * BYTES_PER_CHUNK;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_REG_W  = 6;

  // derived widths
  localparam int LEN_W  = $clog2(NEEDLE_MAX + 1);
  localparam int IDX_W  = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
  localparam int EXT_W  = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
  localparam longint unsigned OFFSET_MAX = (64'd1 << OFFSET_WIDTH) - 64'd1;
  localparam longint unsigned SEEN_CAP   = OFFSET_MAX + 64'd1 + 64'(NEEDLE_MAX);
  localparam int SEEN_W = $clog2(SEEN_CAP + 64'd1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_CHUNK0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_CHUNK1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_CHUNK2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_CHUNK3 = 3'd4;

  // per-beat status from the window chain to the match tracker
  typedef struct packed {
    logic beat;
    logic last;
    logic win_hit;
  } step_t;

  // ascii upper case folds to lower case, everything else passes
  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

### rtl/css_if.sv
// Valid/ready channel interfaces for the text input and the search result.
// Depends on css_pkg for the offset width.
interface css_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

interface css_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 found;
  logic [css_pkg::OFFSET_WIDTH-1:0]     first_offset;
  logic                                 offset_overflow;

  modport source (output valid, output found, output first_offset,
                  output offset_overflow, input ready);
  modport sink   (input valid, input found, input first_offset,
                  input offset_overflow, output ready);
endinterface

### rtl/caseless_substring_search.sv
// Caseless substring search: takes one text byte per cycle, stalling while
// the result is held, and reports, on the last byte of each text, whether the
// configured needle occurred and the start offset of its first occurrence. A
// beat is accepted each cycle the result register is free or draining, and
// the result beat is valid in the cycle after the last text byte is accepted.
// The window compare is a chain of 32 byte cells that all check against
// the needle in the cycle a byte enters. ASCII letters compare without
// regard to case; offsets saturate at 65535 with an overflow flag, and an
// empty needle matches every text at offset zero. Depends on css_pkg,
// css_if, css_cell and css_track.
module caseless_substring_search (
  input  logic                               clk,
  input  logic                               rst_n,
  css_in_if.sink                             in_ch,
  css_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [css_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [css_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import css_pkg::*;

  logic [LEN_REG_W-1:0] len_r, len_nxt;
  logic [CHUNK_W-1:0]   chunk_r   [CHUNK_COUNT];
  logic [CHUNK_W-1:0]   chunk_nxt [CHUNK_COUNT];

  logic [EXT_W-1:0]     len_ext;
  logic [LEN_W-1:0]     eff_len;
  logic [7:0]           needle_arr [NEEDLE_MAX];
  logic [7:0]           cell_in    [NEEDLE_MAX];
  logic [7:0]           cell_out   [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0] cell_hit;
  logic                 in_ready;
  logic                 beat;
  step_t                step;

  // configuration registers
  always_comb begin
    len_nxt   = len_r;
    chunk_nxt = chunk_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEEDLE_LENGTH: len_nxt      = cfg_wdata[LEN_REG_W-1:0];
        CFG_NEEDLE_CHUNK0: chunk_nxt[0] = cfg_wdata;
        CFG_NEEDLE_CHUNK1: chunk_nxt[1] = cfg_wdata;
        CFG_NEEDLE_CHUNK2: chunk_nxt[2] = cfg_wdata;
        CFG_NEEDLE_CHUNK3: chunk_nxt[3] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      for (int c = 0; c < CHUNK_COUNT; c++) begin
        chunk_r[c] <= '0;
      end
    end else begin
      len_r   <= len_nxt;
      chunk_r <= chunk_nxt;
    end
  end

  // effective needle length, clipped to the window
  always_comb begin
    len_ext = EXT_W'(len_r);
    eff_len = (len_ext > EXT_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX) : LEN_W'(len_ext);
  end

  // folded needle bytes; bytes past the registers read as zero
  for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_needle
    if (i < REG_BYTES) begin : g_reg
      assign needle_arr[i] =
        fold_byte(chunk_r[i / BYTES_PER_CHUNK][(i % BYTES_PER_CHUNK) * 8 +: 8]);
    end else begin : g_zero
      assign needle_arr[i] = 8'h00;
    end
  end

  assign in_ch.ready = in_ready;
  assign beat        = in_ch.valid && in_ready;

  // window chain: cell k holds the k-th newest byte and checks it against
  // needle byte len-1-k
  for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
    logic [LEN_W-1:0] diff;
    logic [IDX_W-1:0] idx;

    assign diff = eff_len - LEN_W'(1) - LEN_W'(k);
    assign idx  = diff[IDX_W-1:0];

    if (k == 0) begin : g_head
      assign cell_in[k] = fold_byte(in_ch.text_byte);
    end else begin : g_link
      assign cell_in[k] = cell_out[k-1];
    end

    css_cell u_cell (
      .clk         (clk),
      .shift_en    (beat),
      .byte_in     (cell_in[k]),
      .needle_byte (needle_arr[idx]),
      .active      (LEN_W'(k) < eff_len),
      .byte_out    (cell_out[k]),
      .hit         (cell_hit[k])
    );
  end

  // status of this beat for the tracker
  always_comb begin
    step.beat    = beat;
    step.last    = in_ch.text_last;
    step.win_hit = &cell_hit;
  end

  css_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .eff_len  (eff_len),
    .in_ready (in_ready),
    .out_ch   (out_ch)
  );

endmodule

### rtl/css_cell.sv
// One window cell: holds one folded text byte and compares the byte it is
// about to take against its needle byte. Depends on nothing but the clock.
module css_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] needle_byte,
  input  logic       active,
  output logic [7:0] byte_out,
  output logic       hit
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // shift the window by one byte on every input beat
  always_comb begin
    byte_nxt = shift_en ? byte_in : byte_r;
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out = byte_r;

  // compare against the window after this beat's shift
  assign hit = !active || (byte_in == needle_byte);

endmodule

### rtl/css_track.sv
// Match tracker: counts text bytes, records the first match offset and holds
// the result in an output register. Depends on css_pkg and css_if.
module css_track (
  input  logic                      clk,
  input  logic                      rst_n,
  input  css_pkg::step_t            step,
  input  logic [css_pkg::LEN_W-1:0] eff_len,
  output logic                      in_ready,
  css_out_if.source                 out_ch
);
  import css_pkg::*;

  localparam logic [SEEN_W-1:0] SEEN_CAP_V   = SEEN_W'(SEEN_CAP);
  localparam logic [SEEN_W-1:0] OFFSET_MAX_V = SEEN_W'(OFFSET_MAX);

  logic [SEEN_W-1:0]       seen_r, seen_nxt;
  logic                    match_r, match_nxt;
  logic [SEEN_W-1:0]       start_r, start_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    found_r, found_nxt;
  logic [OFFSET_WIDTH-1:0] offset_r, offset_nxt;
  logic                    over_r, over_nxt;

  logic [SEEN_W-1:0] seen_inc;
  logic [SEEN_W-1:0] len_ext;
  logic [SEEN_W-1:0] start_now;
  logic [SEEN_W-1:0] start_fin;
  logic              hit_now;
  logic              match_fin;
  logic              start_over;

  // take a beat whenever the output register is empty or draining
  assign in_ready = !out_valid_r || out_ch.ready;

  // byte count and first match for this beat
  always_comb begin
    len_ext    = SEEN_W'(eff_len);
    seen_inc   = (seen_r < SEEN_CAP_V) ? seen_r + SEEN_W'(1) : seen_r;
    start_now  = seen_inc - len_ext;
    hit_now    = (eff_len != '0) && !match_r && (seen_inc >= len_ext) && step.win_hit;
    match_fin  = match_r || hit_now;
    start_fin  = hit_now ? start_now : start_r;
    start_over = start_fin > OFFSET_MAX_V;
  end

  // per-text state, cleared after the last byte
  always_comb begin
    seen_nxt  = seen_r;
    match_nxt = match_r;
    start_nxt = start_r;
    if (step.beat) begin
      if (step.last) begin
        seen_nxt  = '0;
        match_nxt = 1'b0;
        start_nxt = '0;
      end else begin
        seen_nxt  = seen_inc;
        match_nxt = match_fin;
        start_nxt = start_fin;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    found_nxt     = found_r;
    offset_nxt    = offset_r;
    over_nxt      = over_r;
    if (step.beat && step.last) begin
      out_valid_nxt = 1'b1;
      if (eff_len == '0) begin
        found_nxt  = 1'b1;
        offset_nxt = '0;
        over_nxt   = 1'b0;
      end else if (match_fin) begin
        found_nxt  = 1'b1;
        offset_nxt = start_over ? OFFSET_WIDTH'(OFFSET_MAX) : start_fin[OFFSET_WIDTH-1:0];
        over_nxt   = start_over;
      end else begin
        found_nxt  = 1'b0;
        offset_nxt = '0;
        over_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      match_r     <= 1'b0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      match_r     <= match_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    offset_r <= offset_nxt;
    over_r   <= over_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.found           = found_r;
  assign out_ch.first_offset    = offset_r;
  assign out_ch.offset_overflow = over_r;

`ifndef SYNTH
  // a result appears only after a last beat
  a_valid_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step.beat && step.last))
    else $error("result raised without a last beat");

  // overflow implies a found match at the saturated offset
  a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && over_r) |-> (found_r && offset_r == OFFSET_WIDTH'(OFFSET_MAX)))
    else $error("overflow without saturated found result");

  // byte count stays within its cap
  a_seen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= SEEN_CAP_V)
    else $error("byte count above cap");

  // per-text state is clear after the last byte
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step.beat && step.last) |=> (seen_r == '0 && !match_r))
    else $error("text state not cleared");
`endif

endmodule
